// ===== design/avm_pkg.sv =====
// ----------------------------------------------------------------------------
// avm_pkg
// opcodes, status codes and shared types of the accumulator machine
// ----------------------------------------------------------------------------
package avm_pkg;

  typedef enum logic [4:0] {
    OP_NOP  = 5'd0,  OP_LDR  = 5'd1,  OP_STR  = 5'd2,  OP_SREG = 5'd3,
    OP_ADD  = 5'd4,  OP_SUB  = 5'd5,  OP_MUL  = 5'd6,  OP_DIV  = 5'd7,
    OP_MOD  = 5'd8,  OP_INC  = 5'd9,  OP_DEC  = 5'd10, OP_NEG  = 5'd11,
    OP_AND  = 5'd12, OP_OR   = 5'd13, OP_XOR  = 5'd14, OP_B    = 5'd15,
    OP_BL   = 5'd16, OP_BZ   = 5'd17, OP_BN   = 5'd18, OP_INT  = 5'd19,
    OP_HALT = 5'd20, OP_PUSH = 5'd21, OP_POP  = 5'd22, OP_SLP  = 5'd23
  } op_t;

  typedef enum logic [2:0] {
    ST_OK = 3'd0, ST_ADDR = 3'd1, ST_PARAM = 3'd2, ST_STACK = 3'd3,
    ST_HALT = 3'd4, ST_DIV0 = 3'd5, ST_BADOP = 3'd6
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE, S_MEM, S_DIV, S_MUL, S_OUT
  } state_t;

  // divider handshake
  typedef struct packed {
    logic        start;
    logic [31:0] num;
    logic [31:0] den;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] quo;
    logic [31:0] rem;
  } div_rsp_t;

endpackage

// ===== design/avm_div.sv =====
// ----------------------------------------------------------------------------
// avm_div
// signed restoring divider, one quotient bit per cycle, truncating
// ----------------------------------------------------------------------------
module avm_div
  import avm_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic [31:0] q_r, q_nxt;
  logic [32:0] rem_r, rem_nxt;
  logic [31:0] d_r, d_nxt;
  logic        nq_r, nq_nxt, nr_r, nr_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic [32:0] shl, dif;

  always_comb begin
    q_nxt = q_r; rem_nxt = rem_r; d_nxt = d_r; nq_nxt = nq_r; nr_nxt = nr_r;
    cnt_nxt = cnt_r; busy_nxt = busy_r;
    shl = {rem_r[31:0], q_r[31]};
    dif = shl - {1'b0, d_r};
    rsp.done = 1'b0;
    rsp.quo  = nq_r ? (32'd0 - q_r) : q_r;
    rsp.rem  = nr_r ? (32'd0 - rem_r[31:0]) : rem_r[31:0];
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = 6'd32;
      rem_nxt  = '0;
      q_nxt    = req.num[31] ? (32'd0 - req.num) : req.num;
      d_nxt    = req.den[31] ? (32'd0 - req.den) : req.den;
      nq_nxt   = req.num[31] ^ req.den[31];
      nr_nxt   = req.num[31];
    end else if (busy_r) begin
      if (cnt_r == 6'd0) begin
        busy_nxt = 1'b0;
        rsp.done = 1'b1;
      end else begin
        cnt_nxt = cnt_r - 6'd1;
        if (!dif[32]) begin
          rem_nxt = dif;
          q_nxt   = {q_r[30:0], 1'b1};
        end else begin
          rem_nxt = shl;
          q_nxt   = {q_r[30:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r <= q_nxt; rem_r <= rem_nxt; d_r <= d_nxt; nq_r <= nq_nxt; nr_r <= nr_nxt;
  end

endmodule

// ===== design/accumulator_vm_execute.sv =====
// ----------------------------------------------------------------------------
// accumulator_vm_execute
// executes one instruction of a one-accumulator machine per input beat
// ----------------------------------------------------------------------------
// input beat: in_cmd, in_operand, in_vm_running; result beat: status, new
// accumulator, next pc, link register, interrupt and sleep requests.
// one instruction at a time: in_stall is high from acceptance until the
// cycle after the result beat is taken. register ops, str and push give
// their result from S_MEM; ldr/pop pass through S_DIV for the synchronous
// data memory read, mul through S_MUL (registered product), and div/mod
// wait in S_DIV for the bit-serial divider. the next input beat is taken
// in the cycle after the result beat at the earliest.
// at reset a clearing pass writes zero to every data memory word, one word
// a cycle, with in_stall high. the result stays on the out_ ports while
// out_stall is high; no new beat is taken meanwhile.
// ----------------------------------------------------------------------------
module accumulator_vm_execute
  import avm_pkg::*;
#(
  parameter int MEM_WORDS   = 256,
  parameter int ROM_WORDS   = 256,
  parameter int STACK_WORDS = 32,
  parameter int IRQ_LINES   = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [4:0]  in_cmd,
  input  logic signed [31:0] in_operand,
  input  logic        in_vm_running,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic signed [31:0] out_acc_value,
  output logic [7:0]  out_next_pc,
  output logic [8:0]  out_link_value,
  output logic        out_irq_valid,
  output logic [3:0]  out_irq_number,
  output logic        out_sleep_valid,
  output logic [30:0] out_sleep_ticks
);

  localparam int AW = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;
  localparam int FLOOR = (STACK_WORDS < MEM_WORDS) ? (MEM_WORDS - STACK_WORDS) : 1;
  localparam logic [AW:0] SP_TOP = (AW+1)'(MEM_WORDS - 1);

  logic [31:0] mem [MEM_WORDS];
  logic [31:0] rd_r;
  logic        we;
  logic [AW-1:0] waddr, raddr;
  logic [31:0] wdata;

  state_t state_r, state_nxt;
  logic [AW:0] clr_r, clr_nxt;
  logic        clearing;

  logic [31:0] acc_r, acc_nxt;
  logic [7:0]  pc_r, pc_nxt;
  logic [8:0]  lr_r, lr_nxt;
  logic [AW:0] sp_r, sp_nxt;
  logic [4:0]  cmd_r, cmd_nxt;
  logic [31:0] opd_r, opd_nxt;
  logic        run_r, run_nxt;
  logic [31:0] prod_r;

  logic [2:0]  st_o_r, st_o_nxt;
  logic        irqv_r, irqv_nxt, slpv_r, slpv_nxt;
  logic [3:0]  irqn_r, irqn_nxt;
  logic [30:0] slpt_r, slpt_nxt;
  logic        ov_r, ov_nxt;

  div_req_t dreq;
  div_rsp_t drsp;

  avm_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rd_r <= mem[raddr];
  end

  // decode of the latched instruction
  logic mem_ok, rom_ok, irq_ok;
  logic [7:0] seq;
  logic [8:0] pc_inc;
  assign mem_ok = !opd_r[31] && ({1'b0, opd_r} < 33'(MEM_WORDS));
  assign rom_ok = !opd_r[31] && ({1'b0, opd_r} < 33'(ROM_WORDS));
  assign irq_ok = !opd_r[31] && ({1'b0, opd_r} < 33'(IRQ_LINES));
  assign pc_inc = {1'b0, pc_r} + 9'd1;
  assign seq    = (32'(pc_inc) >= 32'(ROM_WORDS)) ? 8'd0 : pc_inc[7:0];

  assign clearing = (clr_r != '0);
  assign in_stall = !(state_r == S_IDLE) || clearing;

  always_comb begin
    state_nxt = state_r; clr_nxt = clr_r;
    acc_nxt = acc_r; pc_nxt = pc_r; lr_nxt = lr_r; sp_nxt = sp_r;
    cmd_nxt = cmd_r; opd_nxt = opd_r; run_nxt = run_r;
    st_o_nxt = st_o_r; irqv_nxt = irqv_r; irqn_nxt = irqn_r;
    slpv_nxt = slpv_r; slpt_nxt = slpt_r; ov_nxt = ov_r;
    we = 1'b0; waddr = opd_r[AW-1:0]; wdata = acc_r;
    raddr = opd_r[AW-1:0];
    dreq.start = 1'b0; dreq.num = acc_r; dreq.den = opd_r;
    if (clearing) begin
      we = 1'b1; waddr = AW'(clr_r - 1'b1); wdata = '0;
      clr_nxt = clr_r - 1'b1;
    end
    if (ov_r && !out_stall) ov_nxt = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_valid && !clearing) begin
          cmd_nxt = in_cmd; opd_nxt = in_operand; run_nxt = in_vm_running;
          state_nxt = S_MEM;
        end
      end
      S_MEM: begin
        // first execute cycle: resolve everything but memory loads (ldr, pop), mul and div/mod
        st_o_nxt = ST_OK; irqv_nxt = 1'b0; irqn_nxt = '0;
        slpv_nxt = 1'b0; slpt_nxt = '0;
        state_nxt = S_OUT;
        case (cmd_r)
          OP_LDR: if (mem_ok) state_nxt = S_DIV; else st_o_nxt = ST_ADDR;
          OP_STR: if (mem_ok) begin we = !clearing; pc_nxt = seq; end
                  else st_o_nxt = ST_ADDR;
          OP_SREG: begin acc_nxt = opd_r; pc_nxt = seq; end
          OP_ADD:  begin acc_nxt = acc_r + opd_r; pc_nxt = seq; end
          OP_SUB:  begin acc_nxt = acc_r - opd_r; pc_nxt = seq; end
          OP_MUL:  state_nxt = S_MUL;
          OP_DIV, OP_MOD: begin
            if (opd_r == '0) st_o_nxt = ST_DIV0;
            else begin dreq.start = 1'b1; state_nxt = S_DIV; end
          end
          OP_INC: begin acc_nxt = acc_r + 32'd1; pc_nxt = seq; end
          OP_DEC: begin acc_nxt = acc_r - 32'd1; pc_nxt = seq; end
          OP_NEG: begin acc_nxt = 32'd0 - acc_r; pc_nxt = seq; end
          OP_AND: begin acc_nxt = acc_r & opd_r; pc_nxt = seq; end
          OP_OR:  begin acc_nxt = acc_r | opd_r; pc_nxt = seq; end
          OP_XOR: begin acc_nxt = acc_r ^ opd_r; pc_nxt = seq; end
          OP_B, OP_BL, OP_BZ, OP_BN: begin
            if (!rom_ok) st_o_nxt = ST_ADDR;
            else begin
              pc_nxt = seq;
              if (cmd_r == OP_BL) lr_nxt = pc_inc;
              if (cmd_r == OP_B || cmd_r == OP_BL || (cmd_r == OP_BZ && acc_r == '0) ||
                  (cmd_r == OP_BN && acc_r[31]))
                pc_nxt = opd_r[7:0];
            end
          end
          OP_INT: begin
            if (irq_ok) begin irqv_nxt = 1'b1; irqn_nxt = opd_r[3:0]; pc_nxt = seq; end
            else st_o_nxt = ST_PARAM;
          end
          OP_HALT: st_o_nxt = ST_HALT;
          OP_PUSH: begin
            if (32'(sp_r) < 32'(FLOOR) || 32'(sp_r) >= 32'(MEM_WORDS)) st_o_nxt = ST_STACK;
            else begin
              we = !clearing; waddr = sp_r[AW-1:0];
              sp_nxt = sp_r - 1'b1; pc_nxt = seq;
            end
          end
          OP_POP: begin
            if (sp_r >= SP_TOP) st_o_nxt = ST_STACK;
            else begin
              sp_nxt = sp_r + 1'b1; raddr = AW'(sp_r + 1'b1);
              state_nxt = S_DIV;
            end
          end
          OP_SLP: begin
            if (opd_r[31]) st_o_nxt = ST_PARAM;
            else begin
              pc_nxt = seq;
              if (opd_r != '0 && run_r) begin slpv_nxt = 1'b1; slpt_nxt = opd_r[30:0]; end
            end
          end
          default: st_o_nxt = ST_BADOP;
        endcase
        if (state_nxt == S_OUT) ov_nxt = 1'b1;
      end
      S_DIV: begin
        // memory read data, or divider completion
        if (cmd_r == OP_LDR || cmd_r == OP_POP) begin
          acc_nxt = rd_r; pc_nxt = seq; ov_nxt = 1'b1; state_nxt = S_OUT;
        end else if (drsp.done) begin
          acc_nxt = (cmd_r == OP_DIV) ? drsp.quo : drsp.rem;
          pc_nxt = seq; ov_nxt = 1'b1; state_nxt = S_OUT;
        end
      end
      S_MUL: begin
        acc_nxt = prod_r; pc_nxt = seq; ov_nxt = 1'b1; state_nxt = S_OUT;
      end
      S_OUT: if (!ov_r || !out_stall) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      clr_r   <= (AW+1)'(MEM_WORDS);
      acc_r   <= '0; pc_r <= '0; lr_r <= '0; sp_r <= SP_TOP;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt; clr_r <= clr_nxt;
      acc_r <= acc_nxt; pc_r <= pc_nxt; lr_r <= lr_nxt; sp_r <= sp_nxt;
      ov_r  <= ov_nxt;
    end
    cmd_r <= cmd_nxt; opd_r <= opd_nxt; run_r <= run_nxt;
    st_o_r <= st_o_nxt; irqv_r <= irqv_nxt; irqn_r <= irqn_nxt;
    slpv_r <= slpv_nxt; slpt_r <= slpt_nxt;
    // low word of the product is all that wraps into the accumulator
    prod_r <= acc_r * opd_r;
  end

  assign out_valid       = ov_r;
  assign out_status      = st_o_r;
  assign out_acc_value   = acc_r;
  assign out_next_pc     = pc_r;
  assign out_link_value  = lr_r;
  assign out_irq_valid   = irqv_r;
  assign out_irq_number  = irqn_r;
  assign out_sleep_valid = slpv_r;
  assign out_sleep_ticks = slpt_r;

endmodule
